>>> design/index_to_byte_regroup_strip_stop_core_macros.svh
// Assertion macros used by the checker file.
`ifndef INDEX_TO_BYTE_REGROUP_STRIP_STOP_CORE_MACROS_SVH
`define INDEX_TO_BYTE_REGROUP_STRIP_STOP_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define I2B_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define I2B_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/i2b_pkg.sv
package i2b_pkg;

  localparam int IDX_W       = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int WORD_MAX_W  = 16;
  localparam int ZRUN_W      = 9;
  localparam int WORDS_W     = 6;
  localparam int RES_CNT_W   = 6;

  localparam logic [ZRUN_W-1:0]    ZRUN_MAX    = 9'd511;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 6'd47;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_STOP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  // Control part of one queued operation.
  typedef struct packed {
    logic              lead_one;  // commit a 1 ahead of the zero run
    logic [ZRUN_W-1:0] zcnt;      // zeros to commit after it
    logic              is_last;   // close the message after the bits
    logic              st_over;   // message saw too many words
    logic              st_seen;   // message holds a 1 bit
  } op_ctl_t;

endpackage

>>> design/i2b_front.sv
module i2b_front #(
  parameter int WORD_W    = 11,
  parameter int MAX_WORDS = 32,
  parameter int WCNT_W    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [i2b_pkg::IDX_W-1:0]      word_idx,
  input  logic                           last,
  output logic                           push,
  output i2b_pkg::op_ctl_t               op_ctl,
  output logic [WORD_W-1:0]              op_wbits,
  output logic [WCNT_W-1:0]              op_wcnt
);

  logic                              seen_one_r, seen_one_nxt;
  logic [i2b_pkg::ZRUN_W-1:0]        zero_run_r, zero_run_nxt;
  logic [i2b_pkg::WORDS_W-1:0]       words_seen_r, words_seen_nxt;
  logic                              overflowed_r, overflowed_nxt;

  logic [i2b_pkg::WORD_MAX_W-1:0]    word_ext;
  logic [WORD_W-1:0]                 word;
  logic                              word_nz;
  logic                              over_now;
  logic [WCNT_W-1:0]                 tz;
  logic [i2b_pkg::ZRUN_W:0]          zsum;

  assign word_ext = i2b_pkg::WORD_MAX_W'(word_idx);
  assign word     = word_ext[WORD_W-1:0];
  assign word_nz  = (word != '0);
  assign over_now = (words_seen_r >= i2b_pkg::WORDS_W'(MAX_WORDS));

  // Trailing zeros: position of the lowest 1 bit.
  always_comb begin
    tz = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word[b]) begin
        tz = WCNT_W'(b);
      end
    end
  end

  assign zsum = {1'b0, zero_run_r} + (i2b_pkg::ZRUN_W + 1)'(WORD_W);

  // Commit held-back bits plus the word bits above its lowest 1.
  always_comb begin
    op_ctl          = '0;
    op_ctl.lead_one = !over_now && word_nz && seen_one_r;
    op_ctl.zcnt     = (!over_now && word_nz) ? zero_run_r : '0;
    op_ctl.is_last  = last;
    op_ctl.st_over  = overflowed_r || over_now;
    op_ctl.st_seen  = seen_one_r || (!over_now && word_nz);
    op_wbits        = word;
    op_wcnt         = (!over_now && word_nz) ? (WCNT_W'(WORD_W - 1) - tz) : '0;
    push            = accept && (last || (!over_now && word_nz));
  end

  always_comb begin
    seen_one_nxt   = seen_one_r;
    zero_run_nxt   = zero_run_r;
    words_seen_nxt = words_seen_r;
    overflowed_nxt = overflowed_r;
    if (accept) begin
      if (last) begin
        seen_one_nxt   = 1'b0;
        zero_run_nxt   = '0;
        words_seen_nxt = '0;
        overflowed_nxt = 1'b0;
      end else if (over_now) begin
        overflowed_nxt = 1'b1;
      end else begin
        words_seen_nxt = words_seen_r + 1'b1;
        if (word_nz) begin
          seen_one_nxt = 1'b1;
          zero_run_nxt = i2b_pkg::ZRUN_W'(tz);
        end else if (zsum > {1'b0, i2b_pkg::ZRUN_MAX}) begin
          zero_run_nxt = i2b_pkg::ZRUN_MAX;
        end else begin
          zero_run_nxt = zsum[i2b_pkg::ZRUN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_one_r   <= 1'b0;
      zero_run_r   <= '0;
      words_seen_r <= '0;
      overflowed_r <= 1'b0;
    end else begin
      seen_one_r   <= seen_one_nxt;
      zero_run_r   <= zero_run_nxt;
      words_seen_r <= words_seen_nxt;
      overflowed_r <= overflowed_nxt;
    end
  end

endmodule

>>> design/i2b_queue.sv
module i2b_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign rdata     = slots_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (AW + 1)'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> design/i2b_back.sv
module i2b_back #(
  parameter int WORD_W = 11,
  parameter int WCNT_W = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  i2b_pkg::op_ctl_t                     q_ctl,
  input  logic [WORD_W-1:0]                    q_wbits,
  input  logic [WCNT_W-1:0]                    q_wcnt,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic [i2b_pkg::BYTE_W-1:0]           out_byte,
  output logic [i2b_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_end
);

  localparam int RA_W = i2b_pkg::ZRUN_W + 1;

  logic                               busy_r;
  logic                               one_r;
  logic [RA_W-1:0]                    ra_r;
  logic [WORD_W-1:0]                  wbits_r;
  logic [WCNT_W-1:0]                  wrem_r;
  logic                               last_r, over_r, seen_r;
  logic [7:0]                         head_r;
  logic [2:0]                         hcnt_r;
  logic [i2b_pkg::RES_CNT_W-1:0]      rcnt_r;

  logic                               ov_r;
  logic                               okind_r, oend_r;
  logic [i2b_pkg::BYTE_W-1:0]         obyte_r;
  logic [i2b_pkg::STATUS_W-1:0]       ostat_r;

  logic [3:0]                         space, n, sum;
  logic [7:0]                         bits8;
  logic [WORD_W-1:0]                  wshift;
  logic [15:0]                        hwide;
  logic                               seg_end, in_word, byte_full, room;
  logic                               slot_free, step, emit_byte, emit_stat, load;
  logic [i2b_pkg::STATUS_W-1:0]       st_code;

  assign space  = 4'd8 - {1'b0, hcnt_r};
  assign wshift = wbits_r >> (5'(WORD_W) - 5'(n));

  // Pick the next chunk: the held-back run first, then the word bits.
  always_comb begin
    n       = '0;
    bits8   = '0;
    seg_end = 1'b0;
    in_word = 1'b0;
    if (ra_r != '0) begin
      n     = (ra_r > RA_W'(space)) ? space : ra_r[3:0];
      bits8 = one_r ? (8'd1 << (n - 4'd1)) : 8'd0;
    end else if (wrem_r != '0) begin
      in_word = 1'b1;
      n       = (5'(wrem_r) > 5'(space)) ? space : 4'(wrem_r);
      bits8   = wshift[7:0];
    end else begin
      seg_end = 1'b1;
    end
  end

  assign sum       = {1'b0, hcnt_r} + n;
  assign byte_full = (sum == 4'd8);
  assign hwide     = ({8'd0, head_r} << n) | {8'd0, bits8};
  assign room      = (rcnt_r < i2b_pkg::MAX_RESULTS);
  assign slot_free = !ov_r || out_ready;
  assign step      = busy_r && slot_free;
  assign emit_byte = step && !seg_end && byte_full && room;
  assign emit_stat = step && seg_end && last_r && room;
  assign load      = (!busy_r || (step && seg_end)) && q_valid;
  assign q_pop     = load;

  always_comb begin
    if (over_r) begin
      st_code = i2b_pkg::ST_OVERFLOW;
    end else if (!seen_r) begin
      st_code = i2b_pkg::ST_NO_STOP;
    end else if (hcnt_r != '0) begin
      st_code = i2b_pkg::ST_UNALIGNED;
    end else begin
      st_code = i2b_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      one_r  <= 1'b0;
      ra_r   <= '0;
      wrem_r <= '0;
      last_r <= 1'b0;
      over_r <= 1'b0;
      seen_r <= 1'b0;
      head_r <= '0;
      hcnt_r <= '0;
      rcnt_r <= '0;
    end else begin
      if (step && !seg_end) begin
        one_r <= 1'b0;
        if (in_word) begin
          wbits_r <= wbits_r << n;
          wrem_r  <= wrem_r - WCNT_W'(n);
        end else begin
          ra_r <= ra_r - RA_W'(n);
        end
        if (byte_full) begin
          head_r <= '0;
          hcnt_r <= '0;
          if (room) begin
            rcnt_r <= rcnt_r + 1'b1;
          end
        end else begin
          head_r <= hwide[7:0];
          hcnt_r <= sum[2:0];
        end
      end
      if (step && seg_end) begin
        if (!load) begin
          busy_r <= 1'b0;
        end
        if (last_r) begin
          head_r <= '0;
          hcnt_r <= '0;
        end
      end
      if (load) begin
        busy_r  <= 1'b1;
        one_r   <= q_ctl.lead_one;
        ra_r    <= {1'b0, q_ctl.zcnt} + RA_W'(q_ctl.lead_one);
        wbits_r <= q_wbits;
        wrem_r  <= q_wcnt;
        last_r  <= q_ctl.is_last;
        over_r  <= q_ctl.st_over;
        seen_r  <= q_ctl.st_seen;
        rcnt_r  <= '0;
      end
    end
  end

  // Output register: load a beat when the slot frees, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_byte) begin
      ov_r    <= 1'b1;
      okind_r <= i2b_pkg::KIND_BYTE;
      obyte_r <= hwide[7:0];
      ostat_r <= i2b_pkg::ST_OK;
      oend_r  <= 1'b0;
    end else if (emit_stat) begin
      ov_r    <= 1'b1;
      okind_r <= i2b_pkg::KIND_STATUS;
      obyte_r <= '0;
      ostat_r <= st_code;
      oend_r  <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_byte   = obyte_r;
  assign out_status = ostat_r;
  assign out_end    = oend_r;

endmodule

>>> design/index_to_byte_regroup_strip_stop_core.sv
// Word-index to byte regrouper with stop-bit removal.
//
// Input stream: one beat per word index (in_tdata[10:0]), bits taken most
// significant first; in_tlast marks the final word of a message. All words of
// a message form one bit stream whose final 1 is the stop bit; the zeros after
// it are padding. Output stream: payload bytes (out_tuser = 0) as soon as a
// later 1 bit proves them payload, then one status beat (out_tuser = 1,
// out_tlast = 1) per message: ok, missing stop bit, unaligned stop bit, or too
// many words. On a non-ok status the consumer must discard that message's
// bytes.
// Throughput: the front takes one word per cycle into a small op queue while
// the queue has room; the back commits up to 8 bits per cycle into the byte
// register while its output slot is free, and closes each op in a step of its
// own. With the back idle, a word passes the op queue, the back's op registers
// and the output register, behind any chunks ahead of it, before the first
// byte it completes shows on out_tvalid. When out_tready is low the back holds
// its beat and stops; the front keeps taking words until the queue fills, then
// drops in_tready. Reset (rst_n low, synchronous) empties the queue and the
// output register and clears all message state.
module index_to_byte_regroup_strip_stop_core #(
  parameter int WORD_W      = 11,
  parameter int MAX_WORDS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2b_pkg::IN_TDATA_W-1:0]      in_tdata,   // [10:0] word index, [15:11] zero
  input  logic                                in_tlast,   // last word of the message
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2b_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] data_byte, [9:8] status,
                                                          // [15:10] zero
  output logic                                out_tuser,  // kind: 0 byte, 1 status
  output logic                                out_tlast   // end_of_run
);

  localparam int WCNT_W = $clog2(WORD_W);
  localparam int CTL_W  = $bits(i2b_pkg::op_ctl_t);
  localparam int OP_W   = CTL_W + WORD_W + WCNT_W;

  logic                              accept;
  logic                              push, pop, q_nempty, q_full;
  i2b_pkg::op_ctl_t                  f_ctl, b_ctl;
  logic [WORD_W-1:0]                 f_wbits, b_wbits;
  logic [WCNT_W-1:0]                 f_wcnt, b_wcnt;
  logic [OP_W-1:0]                   q_wdata, q_rdata;
  logic [i2b_pkg::BYTE_W-1:0]        out_byte;
  logic [i2b_pkg::STATUS_W-1:0]      out_status;

  // Accept whenever the op queue has room; every word yields at most one op.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  i2b_front #(
    .WORD_W    (WORD_W),
    .MAX_WORDS (MAX_WORDS),
    .WCNT_W    (WCNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .word_idx   (in_tdata[i2b_pkg::IDX_W-1:0]),
    .last       (in_tlast),
    .push       (push),
    .op_ctl     (f_ctl),
    .op_wbits   (f_wbits),
    .op_wcnt    (f_wcnt)
  );

  assign q_wdata = {f_ctl, f_wbits, f_wcnt};

  i2b_queue #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (q_wdata),
    .pop       (pop),
    .rdata     (q_rdata),
    .not_empty (q_nempty),
    .full      (q_full)
  );

  assign b_ctl   = i2b_pkg::op_ctl_t'(q_rdata[OP_W-1 -: CTL_W]);
  assign b_wbits = q_rdata[WCNT_W +: WORD_W];
  assign b_wcnt  = q_rdata[WCNT_W-1:0];

  i2b_back #(
    .WORD_W (WORD_W),
    .WCNT_W (WCNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_nempty),
    .q_ctl      (b_ctl),
    .q_wbits    (b_wbits),
    .q_wcnt     (b_wcnt),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_end    (out_tlast)
  );

  // Pack the result beat; upper bits stay zero.
  assign out_tdata = {6'd0, out_status, out_byte};

endmodule

>>> design/i2b_checker.sv
`include "index_to_byte_regroup_strip_stop_core_macros.svh"

module i2b_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [i2b_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // Hold a stalled beat.
  `I2B_ASSERT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled beat changed")

  // Only the status beat closes a message.
  `I2B_ASSERT(a_end_is_status, clk, rst_n, out_tvalid |-> (out_tuser == out_tlast), "end flag and kind disagree")

  // Status beats carry no byte, byte beats carry no status, padding is zero.
  `I2B_ASSERT(a_field_clean, clk, rst_n, out_tvalid |-> (out_tdata[15:10] == 6'd0) && (out_tuser ? (out_tdata[7:0] == 8'd0) : (out_tdata[9:8] == 2'd0)), "stray bits in result beat")

  // Drop the output right after reset.
  `I2B_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind index_to_byte_regroup_strip_stop_core i2b_checker u_i2b_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/index_to_byte_regroup_strip_stop_core_test.sv
`timescale 1ns / 1ps

module index_to_byte_regroup_strip_stop_core_test;

  // Block defaults: 11 bits per word, at most 32 words per message.
  localparam int WORD_BITS  = 11;
  localparam int MSG_WORDS  = 32;
  localparam int MAX_BITS   = WORD_BITS * MSG_WORDS;
  localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side
  localparam int TAIL_WAIT  = 24;     // settle time after the last result

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_t;
  typedef enum int {MSG_ALIGNED, MSG_SPARSE, MSG_SILENT, MSG_NOISE, MSG_OVERLONG} msg_kind_t;

  // One output beat, in field terms.
  typedef struct packed {
    logic                         kind;
    logic [i2b_pkg::BYTE_W-1:0]   data_byte;
    logic [i2b_pkg::STATUS_W-1:0] status;
    logic                         end_of_run;
  } beat_t;

  localparam logic [7:0] RX_SHAPE = 8'b1011_0110;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [i2b_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tready = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [i2b_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  index_to_byte_regroup_strip_stop_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [10:0] word index, [15:11] zero
    .in_tlast   (in_tlast),    // last word of the message
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] data_byte, [9:8] status, [15:10] zero
    .out_tuser  (out_tuser),   // kind
    .out_tlast  (out_tlast)    // end_of_run
  );

  always #6 clk = ~clk;

  // Beats the block owes us, oldest first.
  beat_t expected_beats[$];

  // Regrouper state mirrored on the bench side.
  logic [7:0]                  part_byte   = '0;
  logic [2:0]                  part_count  = '0;
  logic                        one_seen    = 1'b0;
  logic [i2b_pkg::ZRUN_W-1:0]  held_zeros  = '0;
  logic [i2b_pkg::WORDS_W-1:0] words_taken = '0;
  logic                        too_many    = 1'b0;
  int                          step_beats;

  // Bookkeeping.
  int       errors         = 0;
  int       words_sent     = 0;
  int       messages_sent  = 0;
  int       bytes_checked  = 0;
  int       status_hits[4] = '{0, 0, 0, 0};
  int       burst_left     = 0;
  bit       tx_bursty      = 1'b0;
  rx_mode_t rx_mode        = RX_ALWAYS;
  logic [5:0] rx_tick      = '0;
  int       idle_cycles    = 0;

  logic [i2b_pkg::IDX_W-1:0] msg_words[$];

  // ---------------------------------------------------------------------------
  // Byte regrouping predictor
  // ---------------------------------------------------------------------------

  // Queue a beat unless this word already produced the cap.
  task automatic queue_beat(input beat_t b);
    if (step_beats < int'(i2b_pkg::MAX_RESULTS))
      expected_beats.insert(expected_beats.size(), b);
    step_beats++;
  endtask

  // Commit one payload bit; a full byte goes out right away.
  task automatic commit_payload_bit(input logic b);
    beat_t bt;
    if (part_count == 3'd7) begin
      bt = '{kind: i2b_pkg::KIND_BYTE, data_byte: {part_byte[6:0], b},
             status: i2b_pkg::ST_OK, end_of_run: 1'b0};
      queue_beat(bt);
      part_byte  = '0;
      part_count = '0;
    end else begin
      part_byte  = {part_byte[6:0], b};
      part_count = part_count + 3'd1;
    end
  endtask

  // Work out what one accepted word makes the block emit.
  task automatic predict_word(input logic [i2b_pkg::IDX_W-1:0] idx, input logic lst);
    logic [i2b_pkg::STATUS_W-1:0] st;
    beat_t                        bt;
    step_beats = 0;
    if (words_taken >= i2b_pkg::WORDS_W'(MSG_WORDS)) begin
      // Word past the limit: drop its bits, remember the overrun.
      too_many = 1'b1;
    end else begin
      words_taken = words_taken + 1'b1;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
        if (!idx[b]) begin
          if (held_zeros != i2b_pkg::ZRUN_MAX)
            held_zeros = held_zeros + 1'b1;
        end else begin
          // A new 1 proves the held 1 and its zeros are payload.
          if (one_seen)
            commit_payload_bit(1'b1);
          for (int z = 0; z < int'(held_zeros); z++)
            commit_payload_bit(1'b0);
          held_zeros = '0;
          one_seen   = 1'b1;
        end
      end
    end
    if (lst) begin
      if (too_many)
        st = i2b_pkg::ST_OVERFLOW;
      else if (!one_seen)
        st = i2b_pkg::ST_NO_STOP;
      else if (part_count != 3'd0)
        st = i2b_pkg::ST_UNALIGNED;
      else
        st = i2b_pkg::ST_OK;
      bt = '{kind: i2b_pkg::KIND_STATUS, data_byte: 8'h00, status: st, end_of_run: 1'b1};
      queue_beat(bt);
      part_byte   = '0;
      part_count  = '0;
      one_seen    = 1'b0;
      held_zeros  = '0;
      words_taken = '0;
      too_many    = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted output beat with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, data_byte: out_tdata[7:0], status: out_tdata[9:8],
              end_of_run: out_tlast};
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none,", $time);
        $display("%0t:   got kind=%0d byte=%02h status=%0d last=%0d",
                 $time, got.kind, got.data_byte, got.status, got.end_of_run);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch: expected kind=%0d byte=%02h status=%0d last=%0d",
                   $time, want.kind, want.data_byte, want.status, want.end_of_run);
          $display("%0t: beat mismatch: got      kind=%0d byte=%02h status=%0d last=%0d",
                   $time, got.kind, got.data_byte, got.status, got.end_of_run);
        end
        if (want.kind == i2b_pkg::KIND_BYTE)
          bytes_checked++;
        else
          status_hits[want.status]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver backpressure: each mode but RX_ALWAYS stalls on its own pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    case (rx_mode)
      RX_ALWAYS:  out_tready <= 1'b1;
      RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_tready <= RX_SHAPE[rx_tick[2:0]];
      default:    out_tready <= (rx_tick[5:4] != 2'b11);  // low while rx_tick[5:4] == 2'b11, a quarter of the time
    endcase
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until the block takes the beat.
  task automatic send_word(input logic [i2b_pkg::IDX_W-1:0] idx, input logic lst);
    if (tx_bursty && burst_left == 0) begin
      // Drop valid for a random gap, then start a new burst.
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0)
      burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= i2b_pkg::IN_TDATA_W'(idx);
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    predict_word(idx, lst);
    words_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_words.size(); i++)
      send_word(msg_words[i], i == msg_words.size() - 1);
    messages_sent++;
  endtask

  // Cut a bit stream (bit 0 first on the wire) into words, MSB first.
  task automatic load_stream(input logic [MAX_BITS-1:0] bits, input int nwords);
    logic [i2b_pkg::IDX_W-1:0] w;
    msg_words.delete();
    for (int i = 0; i < nwords; i++) begin
      for (int b = 0; b < WORD_BITS; b++)
        w[WORD_BITS-1-b] = bits[i*WORD_BITS + b];
      msg_words.insert(msg_words.size(), w);
    end
  endtask

  // Stop offering words until every owed beat has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-word messages: clean byte, no stop bit, all ones, stop on the very
  // first bit, stop on the very last bit.
  task automatic test_single_words();
    logic [i2b_pkg::IDX_W-1:0] picks[5];
    picks = '{11'h59C, 11'h000, 11'h7FF, 11'h400, 11'h001};
    foreach (picks[i]) begin
      msg_words = '{picks[i]};
      send_message();
    end
  endtask

  // Short messages whose bytes straddle word borders.
  task automatic test_multi_word();
    msg_words = '{11'h7FF, 11'h7FF, 11'h400};
    send_message();
    msg_words = '{11'h000, 11'h000, 11'h080};
    send_message();
    msg_words = '{11'h555, 11'h2AA, 11'h555, 11'h300};
    send_message();
    msg_words = '{11'h000, 11'h000};
    send_message();
  endtask

  // A 1, then thirty empty words, then a 1 flushes a long zero run in one
  // word; two more words push the message past the word limit.
  task automatic test_overflow_long_run();
    msg_words.delete();
    msg_words.insert(msg_words.size(), 11'h400);
    repeat (MSG_WORDS - 2) msg_words.insert(msg_words.size(), 11'h000);
    msg_words.insert(msg_words.size(), 11'h001);
    msg_words.insert(msg_words.size(), 11'h7FF);
    msg_words.insert(msg_words.size(), 11'h2A5);
    send_message();
  endtask

  // Random messages, mostly well-formed, until the word goal is reached.
  task automatic test_random_messages(input int goal, input rx_mode_t mode, input bit bursty);
    logic [MAX_BITS-1:0] bits;
    int                  start_count;
    int                  n;
    int                  span;
    int                  k;
    int                  p1;
    int                  stop;
    int                  pick;
    msg_kind_t           kind;
    rx_mode     = mode;
    tx_bursty   = bursty;
    start_count = words_sent;
    while (words_sent - start_count < goal) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? MSG_ALIGNED : (pick < 70) ? MSG_SPARSE :
             (pick < 80) ? MSG_SILENT  : (pick < 96) ? MSG_NOISE  : MSG_OVERLONG;
      bits = '0;
      case (kind)
        MSG_ALIGNED: begin
          // Random payload, stop bit on a byte boundary, zeros after it.
          n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MSG_WORDS)
                                             : $urandom_range(1, 4);
          span = n * WORD_BITS;
          k    = $urandom_range(0, (span - 1) / 8);
          for (int i = 0; i < 8 * k; i++)
            bits[i] = $urandom_range(0, 1);
          bits[8*k] = 1'b1;
          load_stream(bits, n);
        end
        MSG_SPARSE: begin
          // Two ones far apart: the zero run between them flushes at once.
          n    = $urandom_range(2, MSG_WORDS);
          span = n * WORD_BITS;
          p1   = $urandom_range(0, 10);
          if ($urandom_range(0, 1))
            stop = 8 * $urandom_range((p1 + 8) / 8, (span - 1) / 8);
          else
            stop = $urandom_range(p1 + 1, span - 1);
          bits[p1]   = 1'b1;
          bits[stop] = 1'b1;
          load_stream(bits, n);
        end
        MSG_SILENT: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, MSG_WORDS)
                                          : $urandom_range(1, 4);
          load_stream(bits, n);
        end
        MSG_NOISE: begin
          n = $urandom_range(1, 6);
          msg_words.delete();
          repeat (n)
            msg_words.insert(msg_words.size(), i2b_pkg::IDX_W'($urandom_range(0, 2047)));
        end
        default: begin
          n = $urandom_range(MSG_WORDS + 1, MSG_WORDS + 4);
          msg_words.delete();
          repeat (n)
            msg_words.insert(msg_words.size(), i2b_pkg::IDX_W'($urandom_range(0, 2047)));
        end
      endcase
      send_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_words();
    test_multi_word();
    test_overflow_long_run();
    wait_for_drain();

    test_random_messages(65, RX_RANDOM, 1'b1);
    wait_for_drain();
    test_random_messages(65, RX_PATTERN, 1'b0);
    test_random_messages(65, RX_BURSTY, 1'b1);
    test_random_messages(65, RX_ALWAYS, 1'b1);

    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d words in %0d messages; %0d payload bytes checked.",
             words_sent, messages_sent, bytes_checked);
    $display("Message endings seen: ok %0d, no stop %0d, unaligned %0d, too many words %0d.",
             status_hits[i2b_pkg::ST_OK], status_hits[i2b_pkg::ST_NO_STOP],
             status_hits[i2b_pkg::ST_UNALIGNED], status_hits[i2b_pkg::ST_OVERFLOW]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
